### src/spectral_period_detector_assert.svh
// Assertion macros shared by the period detector RTL.
// Included by files that check their own logic; expects clk and rst_n in scope.
`ifndef SPECTRAL_PERIOD_DETECTOR_ASSERT_SVH
`define SPECTRAL_PERIOD_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SPD_ASSERT(label, prop, msg)
`define SPD_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

### src/spd_pkg.sv
// Shared widths, register indexes and reset values of the period detector.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package spd_pkg;

    localparam int TILE_W     = 4;
    localparam int BIN_IDX_W  = 8;
    localparam int PART_W     = 24;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int TCOUNT_W   = 5;
    localparam int FBIN_W     = 7;
    localparam int THR_W      = 16;
    localparam int MINT_W     = 5;
    localparam int BCOUNT_W   = 5;
    localparam int PCT_W      = 7;
    localparam int COLSUM_W   = 32;
    localparam int ROOT_CNT_W = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILE_COUNT = 3'd0,
        CFG_FIRST_BIN  = 3'd1,
        CFG_LAST_BIN   = 3'd2,
        CFG_RATIO_THR  = 3'd3,
        CFG_MIN_TILES  = 3'd4
    } cfg_reg_t;

    localparam logic [TCOUNT_W-1:0] TILE_COUNT_RST = 5'd16;
    localparam logic [FBIN_W-1:0]   FIRST_BIN_RST  = 7'd2;
    localparam logic [FBIN_W-1:0]   LAST_BIN_RST   = 7'd122;
    localparam logic [THR_W-1:0]    RATIO_THR_RST  = 16'd512;
    localparam logic [MINT_W-1:0]   MIN_TILES_RST  = 5'd8;

endpackage

### src/spd_channels.sv
// Valid/ready channel interfaces for FFT bin input and detection results.
// Depends on spd_pkg for field widths.
`timescale 1ns / 1ps

interface spd_in_if import spd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [TILE_W-1:0]        tile_index;
    logic [BIN_IDX_W-1:0]     bin_index;
    logic signed [PART_W-1:0] real_part;
    logic signed [PART_W-1:0] imag_part;
    logic                     final_item;

    modport source (output valid, tile_index, bin_index, real_part, imag_part, final_item,
                    input ready);
    modport sink   (input valid, tile_index, bin_index, real_part, imag_part, final_item,
                    output ready);
endinterface

interface spd_out_if import spd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [BIN_IDX_W-1:0] best_bin;
    logic [BCOUNT_W-1:0]  best_count;
    logic [PCT_W-1:0]     percent;

    modport source (output valid, found, best_bin, best_count, percent, input ready);
    modport sink   (input valid, found, best_bin, best_count, percent, output ready);
endinterface

### src/spectral_period_detector.sv
// Top level of the spectral period detector: accumulation store, scan and result.
// Depends on spd_pkg, the spd_channels interfaces and the assertion macro header.
`timescale 1ns / 1ps
`include "spectral_period_detector_assert.svh"

// Usage
// The in_ch channel carries FFT bins (tile, column bin, real and imaginary part,
// final mark); out_ch carries one detection result per final item. A transfer
// happens on a rising edge with valid and ready both high. Configuration is a
// plain write port (cfg_we, cfg_index, cfg_data) that the user must write only
// while idle; the block itself does not enforce this.
// Each bin passes through the accept cycle, a squaring stage, a sum, a
// one-bit-per-cycle square root and a read-modify-write of the column-sum
// memory; no new bin is accepted until the last one is through. A final item
// then starts the scan, which reads the window taps of each tile one word per
// cycle through the single read port, followed by a restoring divide for the
// percent. The result goes into an output register; the block then clears all
// MAX_TILES*BINS words (2064 by default) of the column-sum memory one word per
// cycle and accepts no bin meanwhile. The same clearing pass runs after reset.
// When the receiver stalls the result stays in the output register and the
// block keeps working; a second result waits in the result state until the
// first one has been transferred.
module spectral_period_detector import spd_pkg::*; #(
    parameter int MAX_TILES = 16,
    parameter int BINS      = 129,
    parameter int WINDOW    = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    spd_in_if.sink               in_ch,
    spd_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int DEPTH    = MAX_TILES * BINS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int BIN_W    = $clog2(BINS);
    localparam int XW       = ((BIN_W > FBIN_W) ? BIN_W : FBIN_W) + 2;
    localparam int TW       = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int CNT_W    = $clog2(MAX_TILES + 1);
    localparam int TAPS     = 3 * WINDOW;
    localparam int KW       = $clog2(TAPS);
    localparam int SUM_W    = COLSUM_W + $clog2(2 * WINDOW);
    localparam int PROD_W   = SUM_W + THR_W;
    localparam int NUM_W    = CNT_W + 7;
    localparam int DCW      = $clog2(NUM_W);
    localparam int STOP_LIM = BINS - 2 * WINDOW - 1;
    localparam int SQ_W     = 2 * PART_W - 1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SQUARE, ST_SUM, ST_ROOT, ST_ACC,
        ST_SCAN_INIT, ST_SCAN_READ, ST_SCAN_DRAIN, ST_SCAN_MUL, ST_SCAN_CMP,
        ST_SCAN_BIN, ST_DIV, ST_RESULT
    } state_t;

    typedef enum logic [1:0] {WIN_LO, WIN_MID, WIN_HI} win_t;

    // Configuration registers.
    logic [TCOUNT_W-1:0] tile_count_reg;
    logic [FBIN_W-1:0]   first_bin_reg;
    logic [FBIN_W-1:0]   last_bin_reg;
    logic [THR_W-1:0]    ratio_thr_reg;
    logic [MINT_W-1:0]   min_tiles_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_count_reg <= TILE_COUNT_RST;
            first_bin_reg  <= FIRST_BIN_RST;
            last_bin_reg   <= LAST_BIN_RST;
            ratio_thr_reg  <= RATIO_THR_RST;
            min_tiles_reg  <= MIN_TILES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_TILE_COUNT: tile_count_reg <= cfg_data[TCOUNT_W-1:0];
                CFG_FIRST_BIN:  first_bin_reg  <= cfg_data[FBIN_W-1:0];
                CFG_LAST_BIN:   last_bin_reg   <= cfg_data[FBIN_W-1:0];
                CFG_RATIO_THR:  ratio_thr_reg  <= cfg_data[THR_W-1:0];
                CFG_MIN_TILES:  min_tiles_reg  <= cfg_data[MINT_W-1:0];
                default: ;
            endcase
        end
    end

    // Datapath and control state.
    state_t                   state_reg;
    logic signed [PART_W-1:0] re_reg;
    logic signed [PART_W-1:0] im_reg;
    logic                     final_reg;
    logic                     in_range_reg;
    logic [ADDR_W-1:0]        acc_addr_reg;
    logic [SQ_W-1:0]          rr_reg;
    logic [SQ_W-1:0]          ii_reg;
    logic [2*PART_W-1:0]      rad_reg;
    logic [PART_W+1:0]        rem_reg;
    logic [PART_W-1:0]        root_reg;
    logic [ROOT_CNT_W-1:0]    iter_reg;
    logic [ADDR_W-1:0]        clr_addr_reg;
    logic signed [XW-1:0]     x_reg;
    logic signed [XW-1:0]     stop_reg;
    logic [TW-1:0]            t_reg;
    logic [KW-1:0]            k_reg;
    logic                     tap_vld_reg;
    win_t                     tap_win_reg;
    logic [SUM_W-1:0]         lo_reg;
    logic [SUM_W-1:0]         mid_reg;
    logic [SUM_W-1:0]         hi_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [PROD_W-1:0]        mid_sh_reg;
    logic [CNT_W-1:0]         passing_reg;
    logic [CNT_W-1:0]         best_reg;
    logic signed [XW-1:0]     best_bin_reg;
    logic                     found_reg;
    logic [NUM_W-1:0]         div_num_reg;
    logic [CNT_W-1:0]         div_rem_reg;
    logic [DCW-1:0]           div_cnt_reg;
    logic                     out_valid_reg;
    logic                     out_found_reg;
    logic [BIN_IDX_W-1:0]     out_bin_reg;
    logic [BCOUNT_W-1:0]      out_count_reg;
    logic [PCT_W-1:0]         out_pct_reg;

    // Memory ports.
    logic [COLSUM_W-1:0]      mem [DEPTH];
    logic [COLSUM_W-1:0]      mem_rdata_reg;
    logic                     mem_we;
    logic                     mem_re;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [ADDR_W-1:0]        mem_raddr;
    logic [COLSUM_W-1:0]      mem_wdata;

    // Combinational helpers.
    logic [CNT_W-1:0]         ntiles;
    logic [COLSUM_W:0]        acc_sum;
    logic signed [XW-1:0]     tap_idx;
    logic signed [XW-1:0]     tap_idx_c;
    logic [ADDR_W-1:0]        tap_addr;
    logic signed [XW-1:0]     start_x;
    logic signed [XW-1:0]     last_x;
    logic signed [XW-1:0]     stop_x;
    logic [PART_W+3:0]        rem_sh;
    logic [PART_W+3:0]        trial;
    logic [CNT_W:0]           div_sh;
    logic [CNT_W-1:0]         pass_next;
    logic                     bin_hit;
    logic                     bin_best;
    logic [CNT_W-1:0]         best_next;
    logic                     in_range;

    always_comb
    begin
        // A tile count of zero counts as one; above the store it counts as the store size.
        if (tile_count_reg == '0)
            ntiles = CNT_W'(1);
        else if (tile_count_reg > MAX_TILES)
            ntiles = CNT_W'(MAX_TILES);
        else
            ntiles = CNT_W'(tile_count_reg);

        acc_sum = {1'b0, mem_rdata_reg} + (COLSUM_W + 1)'(root_reg);

        // Window taps below bin 1 read bin 1.
        tap_idx   = x_reg - XW'(WINDOW) + XW'(k_reg);
        tap_idx_c = (tap_idx < 1) ? XW'(1) : tap_idx;
        tap_addr  = ADDR_W'(ADDR_W'(t_reg) * ADDR_W'(BINS)) + ADDR_W'(tap_idx_c[BIN_W-1:0]);

        start_x = (first_bin_reg < 2) ? XW'(2) : XW'(first_bin_reg);
        last_x  = XW'(last_bin_reg);
        stop_x  = (last_x > XW'(STOP_LIM)) ? XW'(STOP_LIM) : last_x;

        rem_sh = {rem_reg, rad_reg[2*PART_W-1:2*PART_W-2]};
        trial  = (PART_W + 4)'({root_reg, 2'b01});

        div_sh = {div_rem_reg, div_num_reg[NUM_W-1]};

        pass_next = passing_reg + CNT_W'(mid_sh_reg > prod_reg);
        bin_hit   = passing_reg > min_tiles_reg;
        bin_best  = bin_hit && (passing_reg > best_reg);
        best_next = bin_best ? passing_reg : best_reg;

        in_range = (in_ch.tile_index < MAX_TILES) && (in_ch.bin_index < BINS);

        mem_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_ACC) && in_range_reg);
        mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : acc_addr_reg;
        if (state_reg == ST_CLEAR)
            mem_wdata = '0;
        else if (acc_sum[COLSUM_W])
            mem_wdata = '1;
        else
            mem_wdata = acc_sum[COLSUM_W-1:0];
        mem_re    = (state_reg == ST_SUM) || (state_reg == ST_SCAN_READ);
        mem_raddr = (state_reg == ST_SUM) ? acc_addr_reg : tap_addr;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            re_reg        <= '0;
            im_reg        <= '0;
            final_reg     <= 1'b0;
            in_range_reg  <= 1'b0;
            acc_addr_reg  <= '0;
            rr_reg        <= '0;
            ii_reg        <= '0;
            rad_reg       <= '0;
            rem_reg       <= '0;
            root_reg      <= '0;
            iter_reg      <= '0;
            x_reg         <= '0;
            stop_reg      <= '0;
            t_reg         <= '0;
            k_reg         <= '0;
            tap_vld_reg   <= 1'b0;
            tap_win_reg   <= WIN_LO;
            lo_reg        <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            prod_reg      <= '0;
            mid_sh_reg    <= '0;
            passing_reg   <= '0;
            best_reg      <= '0;
            best_bin_reg  <= '0;
            found_reg     <= 1'b0;
            div_num_reg   <= '0;
            div_rem_reg   <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_bin_reg   <= '0;
            out_count_reg <= '0;
            out_pct_reg   <= '0;
        end
        else
        begin
            // The result state reloads the output register itself.
            if (out_valid_reg && out_ch.ready && (state_reg != ST_RESULT))
                out_valid_reg <= 1'b0;

            // Read data of a window tap arrives in the cycle after its address.
            tap_vld_reg <= (state_reg == ST_SCAN_READ);
            if (tap_vld_reg)
            begin
                unique case (tap_win_reg)
                    WIN_LO:  lo_reg  <= lo_reg + SUM_W'(mem_rdata_reg);
                    WIN_MID: mid_reg <= mid_reg + SUM_W'(mem_rdata_reg);
                    WIN_HI:  hi_reg  <= hi_reg + SUM_W'(mem_rdata_reg);
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        re_reg       <= in_ch.real_part;
                        im_reg       <= in_ch.imag_part;
                        final_reg    <= in_ch.final_item;
                        in_range_reg <= in_range;
                        acc_addr_reg <= ADDR_W'(ADDR_W'(in_ch.tile_index) * ADDR_W'(BINS))
                                        + ADDR_W'(in_ch.bin_index);
                        state_reg    <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    rr_reg    <= SQ_W'(re_reg * re_reg);
                    ii_reg    <= SQ_W'(im_reg * im_reg);
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    rad_reg   <= (2 * PART_W)'(rr_reg) + (2 * PART_W)'(ii_reg);
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    iter_reg  <= '0;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    // One result bit per cycle, two radicand bits shifted in.
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= (PART_W + 2)'(rem_sh - trial);
                        root_reg <= {root_reg[PART_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh[PART_W+1:0];
                        root_reg <= {root_reg[PART_W-2:0], 1'b0};
                    end
                    rad_reg  <= rad_reg << 2;
                    iter_reg <= iter_reg + ROOT_CNT_W'(1);
                    if (iter_reg == ROOT_CNT_W'(PART_W - 1))
                        state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    state_reg <= final_reg ? ST_SCAN_INIT : ST_IDLE;
                end
                ST_SCAN_INIT:
                begin
                    found_reg    <= 1'b0;
                    best_reg     <= '0;
                    best_bin_reg <= '0;
                    passing_reg  <= '0;
                    t_reg        <= '0;
                    k_reg        <= '0;
                    lo_reg       <= '0;
                    mid_reg      <= '0;
                    hi_reg       <= '0;
                    x_reg        <= start_x;
                    stop_reg     <= stop_x;
                    if (start_x > stop_x)
                    begin
                        div_num_reg <= '0;
                        div_rem_reg <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= ST_DIV;
                    end
                    else
                        state_reg <= ST_SCAN_READ;
                end
                ST_SCAN_READ:
                begin
                    if (k_reg < KW'(WINDOW))
                        tap_win_reg <= WIN_LO;
                    else if (k_reg < KW'(2 * WINDOW))
                        tap_win_reg <= WIN_MID;
                    else
                        tap_win_reg <= WIN_HI;
                    if (k_reg == KW'(TAPS - 1))
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_SCAN_DRAIN;
                    end
                    else
                        k_reg <= k_reg + KW'(1);
                end
                ST_SCAN_DRAIN:
                begin
                    state_reg <= ST_SCAN_MUL;
                end
                ST_SCAN_MUL:
                begin
                    prod_reg   <= PROD_W'(ratio_thr_reg * SUM_W'(lo_reg + hi_reg));
                    mid_sh_reg <= PROD_W'({mid_reg, 9'b0});
                    state_reg  <= ST_SCAN_CMP;
                end
                ST_SCAN_CMP:
                begin
                    passing_reg <= pass_next;
                    lo_reg      <= '0;
                    mid_reg     <= '0;
                    hi_reg      <= '0;
                    if (CNT_W'(t_reg) == ntiles - CNT_W'(1))
                        state_reg <= ST_SCAN_BIN;
                    else
                    begin
                        t_reg     <= t_reg + TW'(1);
                        state_reg <= ST_SCAN_READ;
                    end
                end
                ST_SCAN_BIN:
                begin
                    if (bin_hit)
                        found_reg <= 1'b1;
                    if (bin_best)
                    begin
                        best_reg     <= passing_reg;
                        best_bin_reg <= x_reg;
                    end
                    if (x_reg == stop_reg)
                    begin
                        div_num_reg <= NUM_W'(best_next * 7'd100);
                        div_rem_reg <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= ST_DIV;
                    end
                    else
                    begin
                        x_reg       <= x_reg + XW'(1);
                        t_reg       <= '0;
                        passing_reg <= '0;
                        state_reg   <= ST_SCAN_READ;
                    end
                end
                ST_DIV:
                begin
                    // Restoring divide; the dividend register ends up holding the quotient.
                    if (div_sh >= (CNT_W + 1)'(ntiles))
                    begin
                        div_rem_reg <= CNT_W'(div_sh - (CNT_W + 1)'(ntiles));
                        div_num_reg <= {div_num_reg[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        div_rem_reg <= div_sh[CNT_W-1:0];
                        div_num_reg <= {div_num_reg[NUM_W-2:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg + DCW'(1);
                    if (div_cnt_reg == DCW'(NUM_W - 1))
                        state_reg <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_found_reg <= found_reg;
                        out_bin_reg   <= found_reg ? best_bin_reg[BIN_IDX_W-1:0] : '0;
                        out_count_reg <= found_reg ? BCOUNT_W'(best_reg) : '0;
                        out_pct_reg   <= found_reg ? PCT_W'(div_num_reg) : '0;
                        clr_addr_reg  <= '0;
                        state_reg     <= ST_CLEAR;
                    end
                end
                default:
                begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.found      = out_found_reg;
    assign out_ch.best_bin   = out_bin_reg;
    assign out_ch.best_count = out_count_reg;
    assign out_ch.percent    = out_pct_reg;

    `SPD_ASSERT(a_acc_exit, (state_reg == ST_ACC) |=> (state_reg == ST_IDLE || state_reg == ST_SCAN_INIT), "accumulate step left to an unexpected state")
    `SPD_ASSERT_IMPL(a_tap_in_scan, tap_vld_reg, state_reg == ST_SCAN_READ || state_reg == ST_SCAN_DRAIN, "window tap data outside the scan read phase")
    `SPD_ASSERT_IMPL(a_pass_bound, state_reg == ST_SCAN_BIN, passing_reg <= ntiles, "passing count exceeds tiles in use")
    `SPD_ASSERT_IMPL(a_not_found_zero, out_ch.valid && !out_ch.found, out_ch.best_count == '0 && out_ch.percent == '0, "empty result carries a count")

endmodule
